>>> hw/rtl/quadrotor_motor_mixer_macros.svh
// assertion macros for the motor mixer
`ifndef QUADROTOR_MOTOR_MIXER_MACROS_SVH
`define QUADROTOR_MOTOR_MIXER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define QMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixer assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define QMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixer assertion failed");

`endif

>>> hw/rtl/qmm_pkg.sv
// types, constants and helpers shared by the motor mixer
`default_nettype none
package qmm_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned ROOT_SPS_DEFAULT = 2;
  localparam int unsigned ROOT_BITS = 20;
  localparam int unsigned ROOT_IN_W = 2 * ROOT_BITS;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned Q_W = PROD_W - 8;
  localparam int unsigned SUM_W = Q_W + 3;
  localparam int unsigned MUL_W = 16 + ROOT_BITS;
  localparam int unsigned CMD_W = MUL_W + 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_ARM_GAIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRUST_GAIN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DRAG_GAIN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CMD_GAIN    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CMD_OFFSET  = 3'd5;

  localparam logic [31:0] ARM_GAIN_RST    = 32'd100930458;
  localparam logic [31:0] THRUST_GAIN_RST = 32'd8579088;
  localparam logic [31:0] DRAG_GAIN_RST   = 32'd520325203;
  localparam logic [23:0] MAX_SPEED_RST   = 24'd607720;
  localparam logic [15:0] CMD_GAIN_RST    = 16'd15626;
  localparam logic [15:0] CMD_OFFSET_RST  = 16'd6623;

  localparam logic [7:0] CMD_MAX = 8'd200;

  // per lane: arm term from roll (else pitch), negated arm, negated yaw
  localparam logic [LANES-1:0] LANE_USE_ROLL = 4'b1010;
  localparam logic [LANES-1:0] LANE_NEG_ARM  = 4'b0110;
  localparam logic [LANES-1:0] LANE_NEG_YAW  = 4'b0101;

  typedef struct packed {
    logic signed [31:0] roll_torque;
    logic signed [31:0] pitch_torque;
    logic signed [31:0] yaw_torque;
    logic signed [31:0] total_thrust;
  } mixer_in_t;

  typedef struct packed {
    logic [7:0] motor_slot0;
    logic [7:0] motor_slot1;
    logic [7:0] motor_slot2;
    logic [7:0] motor_slot3;
  } mixer_out_t;

  typedef struct packed {
    logic [31:0] arm_mix_gain;
    logic [31:0] thrust_mix_gain;
    logic [31:0] drag_mix_gain;
    logic [23:0] max_speed_sq;
    logic [15:0] cmd_gain;
    logic [15:0] cmd_offset;
  } cfg_t;

  // floored products: value in q16, plus for roll, pitch and yaw a flag for a nonzero dropped fraction
  typedef struct packed {
    logic signed [Q_W-1:0] roll_q;
    logic                  roll_f;
    logic signed [Q_W-1:0] pitch_q;
    logic                  pitch_f;
    logic signed [Q_W-1:0] yaw_q;
    logic                  yaw_f;
    logic signed [Q_W-1:0] thr_q;
  } front_t;

  typedef struct packed {
    logic [ROOT_IN_W-1:0] rem;
    logic [ROOT_IN_W-1:0] root;
  } root_t;

  // one step of the bitwise integer square root
  function automatic root_t root_step(input root_t s, input int unsigned j);
    logic [ROOT_IN_W-1:0] b;
    logic [ROOT_IN_W:0]   t;
    root_t                o;
    b = ROOT_IN_W'(1) << (ROOT_IN_W - 2 - 2 * j);
    t = {1'b0, s.root} + {1'b0, b};
    if ({1'b0, s.rem} >= t) begin
      o.rem  = s.rem - t[ROOT_IN_W-1:0];
      o.root = (s.root >> 1) + b;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/qmm_front.sv
// gain products of the four wrench terms, floored to q16
`default_nettype none
module qmm_front (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire qmm_pkg::cfg_t      cfg,
  input  wire qmm_pkg::mixer_in_t din,
  output qmm_pkg::front_t         dout
);
  import qmm_pkg::*;

  logic signed [PROD_W-1:0] p_roll;
  logic signed [PROD_W-1:0] p_pitch;
  logic signed [PROD_W-1:0] p_yaw;
  logic signed [PROD_W-1:0] p_thr;

  assign p_roll  = din.roll_torque  * $signed({1'b0, cfg.arm_mix_gain});
  assign p_pitch = din.pitch_torque * $signed({1'b0, cfg.arm_mix_gain});
  assign p_yaw   = din.yaw_torque   * $signed({1'b0, cfg.drag_mix_gain});
  assign p_thr   = din.total_thrust * $signed({1'b0, cfg.thrust_mix_gain});

  always_ff @(posedge clk) begin
    if (en) begin
      dout.roll_q  <= p_roll[PROD_W-1:8];
      dout.roll_f  <= |p_roll[7:0];
      dout.pitch_q <= p_pitch[PROD_W-1:8];
      dout.pitch_f <= |p_pitch[7:0];
      dout.yaw_q   <= p_yaw[PROD_W-1:8];
      dout.yaw_f   <= |p_yaw[7:0];
      dout.thr_q   <= p_thr[PROD_W-1:8];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/qmm_lane.sv
// one mixer lane: sum, clamp, pipelined square root, command map
`default_nettype none
module qmm_lane #(
  parameter int unsigned LANE = 0,
  parameter int unsigned ROOT_STEPS_PER_STAGE = qmm_pkg::ROOT_SPS_DEFAULT,
  localparam int unsigned RS = qmm_pkg::ROOT_BITS / ROOT_STEPS_PER_STAGE,
  localparam int unsigned LANE_STAGES = 3 + RS
) (
  input  wire logic                               clk,
  input  wire logic [LANE_STAGES-1:0]             en,
  input  wire qmm_pkg::cfg_t                      cfg,
  input  wire logic signed [qmm_pkg::Q_W-1:0]     arm_q,
  input  wire logic                               arm_f,
  input  wire logic signed [qmm_pkg::Q_W-1:0]     yaw_q,
  input  wire logic                               yaw_f,
  input  wire logic signed [qmm_pkg::Q_W-1:0]     thr_q,
  output logic [7:0]                              cmd
);
  import qmm_pkg::*;

  localparam logic [7:0] CMD_LOW = (LANE == LANES - 1) ? 8'd0 : 8'd1;
  localparam logic signed [CMD_W-1:0] C_ONE = CMD_W'(1) << 24;
  localparam logic signed [CMD_W-1:0] C_MAX = CMD_W'(CMD_MAX) << 24;

  logic signed [SUM_W-1:0] arm_t;
  logic signed [SUM_W-1:0] yaw_t;
  logic signed [SUM_W-1:0] sum;
  logic [ROOT_IN_W-1:0]    lim;
  root_t                   rs [0:RS];
  logic [MUL_W-1:0]        prod;
  logic signed [CMD_W-1:0] c;

  // floor of the negated product is minus floor minus one when bits dropped
  always_comb begin
    if (LANE_NEG_ARM[LANE]) begin
      arm_t = -SUM_W'(arm_q) - SUM_W'({1'b0, arm_f});
    end else begin
      arm_t = SUM_W'(arm_q);
    end
    if (LANE_NEG_YAW[LANE]) begin
      yaw_t = -SUM_W'(yaw_q) - SUM_W'({1'b0, yaw_f});
    end else begin
      yaw_t = SUM_W'(yaw_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum <= arm_t + yaw_t + SUM_W'(thr_q);
    end
  end

  assign lim = {cfg.max_speed_sq, 16'd0};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rs[0].root <= '0;
      if (sum[SUM_W-1]) begin
        rs[0].rem <= '0;
      end else if (sum > $signed({{(SUM_W-ROOT_IN_W){1'b0}}, lim})) begin
        rs[0].rem <= lim;
      end else begin
        rs[0].rem <= sum[ROOT_IN_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < RS; k++) begin : g_root
    root_t st;
    always_comb begin
      st = rs[k];
      for (int unsigned j = 0; j < ROOT_STEPS_PER_STAGE; j++) begin
        st = root_step(st, k * ROOT_STEPS_PER_STAGE + j);
      end
    end
    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        rs[k+1] <= st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2+RS]) begin
      prod <= cfg.cmd_gain * rs[RS].root[ROOT_BITS-1:0];
    end
  end

  assign c = $signed({2'b00, prod}) - $signed(CMD_W'({cfg.cmd_offset, 16'd0}));

  always_comb begin
    if (c < C_ONE) begin
      cmd = CMD_LOW;
    end else if (c > C_MAX) begin
      cmd = CMD_MAX;
    end else begin
      cmd = c[31:24];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/quadrotor_motor_mixer.sv
// quadrotor motor mixer top level: config registers, pipeline control, slot merge
//
// in channel: in_valid/in_stall carry one wrench word (roll, pitch, yaw torque
// and total thrust). out channel: out_valid/out_stall carry one word of four
// motor commands. a word moves at an edge where valid is high and stall low.
// every input word gives exactly one output word, in order.
// the path from acceptance to out_valid runs through one product stage, per
// lane a sum, clamp, the square root pipeline (ROOT_STEPS_PER_STAGE root bits
// per stage) and a command multiply, then the output register.
// throughput is one word per cycle while out_stall is low; the root pipeline sets the depth.
// when out_stall holds a waiting word, upstream stages keep moving into any
// empty slot, so new words are taken until the pipeline is full.
// configuration: cfg_we writes cfg_data to register cfg_addr;
// indexes past the last register are ignored. write only while idle.
// reset (rst, synchronous) empties the pipeline and restores register defaults.
`default_nettype none
module quadrotor_motor_mixer #(
  parameter int unsigned ROOT_STEPS_PER_STAGE = qmm_pkg::ROOT_SPS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire qmm_pkg::mixer_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output qmm_pkg::mixer_out_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [qmm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [qmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import qmm_pkg::*;
  `include "quadrotor_motor_mixer_macros.svh"

  localparam int unsigned RS = ROOT_BITS / ROOT_STEPS_PER_STAGE;
  localparam int unsigned LANE_STAGES = 3 + RS;
  localparam int unsigned N = LANE_STAGES + 2;

  cfg_t       cfg;
  front_t     front;
  logic [N-1:0] vld;
  logic [N-1:0] ready;
  logic [7:0] cmd [0:LANES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_mix_gain    <= ARM_GAIN_RST;
      cfg.thrust_mix_gain <= THRUST_GAIN_RST;
      cfg.drag_mix_gain   <= DRAG_GAIN_RST;
      cfg.max_speed_sq    <= MAX_SPEED_RST;
      cfg.cmd_gain        <= CMD_GAIN_RST;
      cfg.cmd_offset      <= CMD_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ARM_GAIN:    cfg.arm_mix_gain    <= cfg_data;
        REG_THRUST_GAIN: cfg.thrust_mix_gain <= cfg_data;
        REG_DRAG_GAIN:   cfg.drag_mix_gain   <= cfg_data;
        REG_MAX_SPEED:   cfg.max_speed_sq    <= cfg_data[23:0];
        REG_CMD_GAIN:    cfg.cmd_gain        <= cfg_data[15:0];
        REG_CMD_OFFSET:  cfg.cmd_offset      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // a stage loads when it is empty or the stage after it moves
  always_comb begin
    ready[N-1] = !vld[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      ready[i] = !vld[i] || ready[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (ready[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = vld[N-1];

  qmm_front u_front (
    .clk  (clk),
    .en   (ready[0]),
    .cfg  (cfg),
    .din  (in_data),
    .dout (front)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    qmm_lane #(
      .LANE                 (l),
      .ROOT_STEPS_PER_STAGE (ROOT_STEPS_PER_STAGE)
    ) u_lane (
      .clk   (clk),
      .en    (ready[LANE_STAGES:1]),
      .cfg   (cfg),
      .arm_q (LANE_USE_ROLL[l] ? front.roll_q : front.pitch_q),
      .arm_f (LANE_USE_ROLL[l] ? front.roll_f : front.pitch_f),
      .yaw_q (front.yaw_q),
      .yaw_f (front.yaw_f),
      .thr_q (front.thr_q),
      .cmd   (cmd[l])
    );
  end

  // slot order of the motor bus
  always_ff @(posedge clk) begin
    if (ready[N-1]) begin
      out_data.motor_slot0 <= cmd[0];
      out_data.motor_slot1 <= cmd[2];
      out_data.motor_slot2 <= cmd[3];
      out_data.motor_slot3 <= cmd[1];
    end
  end

  `QMM_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld[0])
  `QMM_ASSERT_IMP(a_full_blocks, (&vld) && out_stall, in_stall)
  `QMM_ASSERT_IMP(a_slot_range, out_valid,
                  out_data.motor_slot0 != 8'd0 && out_data.motor_slot0 <= CMD_MAX &&
                  out_data.motor_slot1 != 8'd0 && out_data.motor_slot1 <= CMD_MAX &&
                  out_data.motor_slot2 <= CMD_MAX &&
                  out_data.motor_slot3 != 8'd0 && out_data.motor_slot3 <= CMD_MAX)

endmodule
`default_nettype wire

>>> sim/tb_quadrotor_motor_mixer.sv
// self-checking testbench for the quadrotor motor mixer
module tb_quadrotor_motor_mixer;
  import qmm_pkg::*;

  localparam int PLAN_ROWS = 21;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
  localparam mixer_out_t IDLE_CMDS = '{8'd1, 8'd1, 8'd0, 8'd1};
  localparam mixer_out_t NO_CMDS = '0;
  localparam cfg_t RESET_SETTING = '{ARM_GAIN_RST, THRUST_GAIN_RST, DRAG_GAIN_RST,
                                     MAX_SPEED_RST, CMD_GAIN_RST, CMD_OFFSET_RST};
  localparam cfg_t HIGH_SETTING = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    24'hFF_FFFF, 16'hFFFF, 16'h0000};
  localparam cfg_t LOW_SETTING = '{32'h0, 32'h0, 32'h0, 24'h0, 16'h0, 16'hFFFF};

  typedef struct packed {
    mixer_in_t  wrench;
    logic       typed;
    mixer_out_t want;
  } plan_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  mixer_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  mixer_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t       regs_now = RESET_SETTING;
  mixer_out_t pending_cmds [$];
  mixer_out_t head_cmd;
  int         bad_words = 0;
  bit         quiet = 1'b0;

  // roll, pitch, yaw, thrust | typed | slot0..slot3
  plan_row_t plan [PLAN_ROWS] = '{
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, IDLE_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000}, 1'b1, IDLE_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001}, 1'b1, IDLE_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, IDLE_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF}, 1'b0, NO_CMDS},
    '{'{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h000A_0000}, 1'b0, NO_CMDS},
    '{'{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h000A_0000}, 1'b0, NO_CMDS},
    '{'{32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h000A_0000}, 1'b0, NO_CMDS},
    '{'{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h000A_0000}, 1'b0, NO_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h000A_0000}, 1'b0, NO_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h000A_0000}, 1'b0, NO_CMDS},
    '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, NO_CMDS},
    '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, NO_CMDS},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NO_CMDS},
    '{'{32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA}, 1'b0, NO_CMDS},
    '{'{32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555}, 1'b0, NO_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0009_CF5C}, 1'b0, NO_CMDS},
    '{'{32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h0009_CF5C}, 1'b0, NO_CMDS},
    '{'{32'h0000_0000, 32'hFFFF_8000, 32'h0000_0000, 32'h0009_CF5C}, 1'b0, NO_CMDS},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_199A, 32'h0009_CF5C}, 1'b0, NO_CMDS},
    '{'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, NO_CMDS}
  };

  quadrotor_motor_mixer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_quadrotor_motor_mixer: FAIL");
    $finish;
  end

  // q16 value times q24.8 gain, floored back to q16
  function automatic longint floor_q16(longint x, logic [31:0] g);
    longint p;
    p = x * longint'({32'b0, g});
    return p >>> 8;
  endfunction

  function automatic longint unsigned speed_root(longint unsigned v);
    longint unsigned r, trial;
    r = 0;
    for (int i = 19; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic logic [7:0] motor_cmd(longint sq, bit last_lane);
    longint lim, c;
    longint unsigned spd;
    lim = longint'(regs_now.max_speed_sq) << 16;
    if (sq < 0) sq = 0;
    if (sq > lim) sq = lim;
    spd = speed_root(sq);
    c = longint'(regs_now.cmd_gain) * longint'(spd) - (longint'(regs_now.cmd_offset) << 16);
    if (c < (longint'(1) << 24)) return last_lane ? 8'd0 : 8'd1;
    if (c > (longint'(CMD_MAX) << 24)) return CMD_MAX;
    return 8'(c >>> 24);
  endfunction

  function automatic mixer_out_t mix_motors(mixer_in_t w);
    longint r, p, y, t;
    longint ar, ap, nar, nap, dy, ndy, tt;
    mixer_out_t o;
    r = longint'(w.roll_torque);
    p = longint'(w.pitch_torque);
    y = longint'(w.yaw_torque);
    t = longint'(w.total_thrust);
    ar  = floor_q16(r, regs_now.arm_mix_gain);
    nar = floor_q16(-r, regs_now.arm_mix_gain);
    ap  = floor_q16(p, regs_now.arm_mix_gain);
    nap = floor_q16(-p, regs_now.arm_mix_gain);
    dy  = floor_q16(y, regs_now.drag_mix_gain);
    ndy = floor_q16(-y, regs_now.drag_mix_gain);
    tt  = floor_q16(t, regs_now.thrust_mix_gain);
    o.motor_slot0 = motor_cmd(ap + ndy + tt, 1'b0);
    o.motor_slot1 = motor_cmd(nap + ndy + tt, 1'b0);
    o.motor_slot2 = motor_cmd(ar + dy + tt, 1'b1);
    o.motor_slot3 = motor_cmd(nar + dy + tt, 1'b0);
    return o;
  endfunction

  function automatic logic [31:0] rand_field(int lo, int hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return 32'($urandom_range(hi - lo)) + 32'(lo);
    if (pick < 78) return 32'($urandom_range(600)) - 32'd300;
    if (pick < 92) return $urandom();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic mixer_in_t random_wrench();
    mixer_in_t w;
    w.roll_torque  = rand_field(-98304, 98304);
    w.pitch_torque = rand_field(-98304, 98304);
    w.yaw_torque   = rand_field(-19661, 19661);
    w.total_thrust = rand_field(0, 1310720);
    return w;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.arm_mix_gain    = $urandom_range(2 * ARM_GAIN_RST);
    s.thrust_mix_gain = $urandom_range(2 * THRUST_GAIN_RST);
    s.drag_mix_gain   = $urandom_range(2 * DRAG_GAIN_RST);
    s.max_speed_sq    = 24'($urandom());
    s.cmd_gain        = 16'($urandom());
    s.cmd_offset      = 16'($urandom_range(2 * CMD_OFFSET_RST));
    return s;
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ARM_GAIN:    regs_now.arm_mix_gain = val;
      REG_THRUST_GAIN: regs_now.thrust_mix_gain = val;
      REG_DRAG_GAIN:   regs_now.drag_mix_gain = val;
      REG_MAX_SPEED:   regs_now.max_speed_sq = val[23:0];
      REG_CMD_GAIN:    regs_now.cmd_gain = val[15:0];
      REG_CMD_OFFSET:  regs_now.cmd_offset = val[15:0];
      default: ;
    endcase
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic load_setting(cfg_t s);
    write_reg(REG_SPARE_6, $urandom());
    write_reg(REG_ARM_GAIN, s.arm_mix_gain);
    write_reg(REG_THRUST_GAIN, s.thrust_mix_gain);
    write_reg(REG_DRAG_GAIN, s.drag_mix_gain);
    write_reg(REG_MAX_SPEED, {8'($urandom()), s.max_speed_sq});
    write_reg(REG_CMD_GAIN, {16'($urandom()), s.cmd_gain});
    write_reg(REG_CMD_OFFSET, {16'($urandom()), s.cmd_offset});
    write_reg(REG_SPARE_7, $urandom());
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(mixer_in_t w, bit typed, mixer_out_t want);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds.push_back(typed ? want : mix_motors(w));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int count, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      send_word(random_wrench(), 1'b0, NO_CMDS);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) $display("unexpected motor word %h", out_data);
      end else begin
        head_cmd = pending_cmds.pop_front();
        if (out_data !== head_cmd) begin
          bad_words++;
          if (bad_words <= 10)
            $display("motor word mismatch: got %0d %0d %0d %0d expected %0d %0d %0d %0d",
                     out_data.motor_slot0, out_data.motor_slot1, out_data.motor_slot2,
                     out_data.motor_slot3, head_cmd.motor_slot0, head_cmd.motor_slot1,
                     head_cmd.motor_slot2, head_cmd.motor_slot3);
        end
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < 18);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++)
      send_word(plan[i].wrench, plan[i].typed, plan[i].want);

    settle();
    load_setting(HIGH_SETTING);
    run_phase(100, -1);

    settle();
    load_setting(LOW_SETTING);
    run_phase(60, -1);

    // back-to-back stretch with no gaps on either side
    settle();
    quiet = 1'b1;
    load_setting(random_setting());
    run_phase(150, -1);

    settle();
    quiet = 1'b0;
    load_setting(random_setting());
    run_phase(130, 50);

    settle();
    load_setting(RESET_SETTING);
    run_phase(240, -1);

    settle();
    repeat (40) @(posedge clk);
    if (bad_words == 0 && pending_cmds.size() == 0)
      $display("tb_quadrotor_motor_mixer: PASS");
    else
      $display("tb_quadrotor_motor_mixer: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/qmm_pkg.sv
hw/rtl/qmm_front.sv
hw/rtl/qmm_lane.sv
hw/rtl/quadrotor_motor_mixer.sv
sim/tb_quadrotor_motor_mixer.sv
